// ===== hw/rtl/fsne_pkg.sv =====
`timescale 1ns / 1ps

package fsne_pkg;

   localparam int NAME_LEN = 11;
   localparam int BASE_LEN = 8;
   localparam int EXT_LEN  = NAME_LEN - BASE_LEN;
   localparam int POS_W    = 4;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CASE_OFS = 8'h20;

   localparam logic [POS_W-1:0] POS_BASE_END = POS_W'(BASE_LEN);
   localparam logic [POS_W-1:0] POS_NAME_END = POS_W'(NAME_LEN);

   typedef enum logic [1:0] {
      PH_BASE   = 2'd0,
      PH_AFTER8 = 2'd1,
      PH_EXT    = 2'd2,
      PH_SKIP   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_BAD   = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic       allowed;
      logic       lower;
      logic       upper;
      logic       dot;
      logic [7:0] folded;
   } char_class_type;

endpackage

// ===== hw/rtl/fsne_classify.sv =====
`timescale 1ns / 1ps

module fsne_classify (
   input  logic [7:0]              ch,
   output fsne_pkg::char_class_type cls
);
   import fsne_pkg::*;

   logic lower;
   logic upper;
   logic symbol;
   logic digit;

   always_comb begin
      lower  = (ch >= 8'h61) && (ch <= 8'h7A);
      upper  = (ch >= 8'h41) && (ch <= 8'h5A);
      digit  = (ch >= 8'h30) && (ch <= 8'h39);
      symbol = (ch == 8'h21) || ((ch >= 8'h23) && (ch <= 8'h29)) || (ch == 8'h2D) ||
               (ch == 8'h5E) || (ch == 8'h5F) || (ch == 8'h7B) || (ch == 8'h7D) ||
               (ch == 8'h7E);

      cls.allowed = lower || upper || digit || symbol;
      cls.lower   = lower;
      cls.upper   = upper;
      cls.dot     = (ch == CH_DOT);
      cls.folded  = lower ? (ch - CASE_OFS) : ch;
   end

endmodule

// ===== hw/rtl/fat_short_name_encoder_core.sv =====
`timescale 1ns / 1ps
// rsp_valid rises in the cycle after the NUL transfer; other characters give no result.
// Throughput: one character per cycle; req_ready drops only while a result is held
// in the output register and rsp_ready is low.
// Reset (synchronous, active high): name bytes to spaces, position, phase, case flags
// and error flag cleared, output register empty.
module fat_short_name_encoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_ch,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_base_name,
   output logic [23:0] rsp_ext_name,
   output logic        rsp_base_lower,
   output logic        rsp_ext_lower,
   output logic [1:0]  rsp_status
);
   import fsne_pkg::*;

   char_class_type cls;

   logic [7:0]       name_ff [NAME_LEN];
   logic [7:0]       name_in [NAME_LEN];
   logic [POS_W-1:0] position_ff, position_in;
   phase_type        phase_ff, phase_in;
   logic [3:0]       case_ff, case_in;
   logic             bad_ff, bad_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [63:0]      base_ff, base_in;
   logic [23:0]      ext_ff, ext_in;
   logic             base_lower_ff, base_lower_in;
   logic             ext_lower_ff, ext_lower_in;
   status_type       status_ff, status_in;

   logic             accept;
   logic             end_of_name;
   logic [POS_W-1:0] pos_inc;

   fsne_classify u_classify (
      .ch  (req_ch),
      .cls (cls)
   );

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign accept      = req_valid && req_ready;
   assign end_of_name = accept && (req_ch == CH_NUL);
   assign pos_inc     = position_ff + POS_W'(1);

   // next state
   always_comb begin
      name_in     = name_ff;
      position_in = position_ff;
      phase_in    = phase_ff;
      case_in     = case_ff;
      bad_in      = bad_ff;

      if (end_of_name) begin
         for (int i = 0; i < NAME_LEN; i++) begin
            name_in[i] = CH_SPACE;
         end
         position_in = '0;
         phase_in    = PH_BASE;
         case_in     = '0;
         bad_in      = 1'b0;
      end else if (accept) begin
         unique case (phase_ff)
            PH_BASE: begin
               if (cls.dot) begin
                  position_in = POS_BASE_END;
                  phase_in    = PH_EXT;
               end else begin
                  case_in[0] = case_ff[0] | cls.lower;
                  case_in[1] = case_ff[1] | cls.upper;
                  if (!cls.allowed) begin
                     bad_in   = 1'b1;
                     phase_in = PH_SKIP;
                  end else begin
                     name_in[position_ff] = cls.folded;
                     position_in          = pos_inc;
                     if (pos_inc >= POS_BASE_END) begin
                        phase_in = PH_AFTER8;
                     end
                  end
               end
            end
            PH_AFTER8: begin
               position_in = POS_BASE_END;
               if (cls.dot) begin
                  phase_in = PH_EXT;
               end else begin
                  case_in[2] = case_ff[2] | cls.lower;
                  case_in[3] = case_ff[3] | cls.upper;
                  if (!cls.allowed) begin
                     bad_in   = 1'b1;
                     phase_in = PH_SKIP;
                  end else begin
                     name_in[BASE_LEN] = cls.folded;
                     position_in       = POS_BASE_END + POS_W'(1);
                     phase_in          = PH_EXT;
                  end
               end
            end
            PH_EXT: begin
               case_in[2] = case_ff[2] | cls.lower;
               case_in[3] = case_ff[3] | cls.upper;
               if (!cls.allowed) begin
                  bad_in   = 1'b1;
                  phase_in = PH_SKIP;
               end else begin
                  name_in[position_ff] = cls.folded;
                  position_in          = pos_inc;
                  if (pos_inc >= POS_NAME_END) begin
                     phase_in = PH_SKIP;
                  end
               end
            end
            PH_SKIP: begin
            end
            default: begin
            end
         endcase
      end
   end

   // result
   always_comb begin
      rsp_valid_in  = end_of_name || (rsp_valid_ff && !rsp_ready);
      base_in       = base_ff;
      ext_in        = ext_ff;
      base_lower_in = base_lower_ff;
      ext_lower_in  = ext_lower_ff;
      status_in     = status_ff;

      if (end_of_name) begin
         if (bad_ff) begin
            status_in = ST_BAD;
         end else if (name_ff[0] == CH_SPACE) begin
            status_in = ST_EMPTY;
         end else begin
            status_in = ST_OK;
         end

         if (!bad_ff && (name_ff[0] != CH_SPACE)) begin
            for (int i = 0; i < BASE_LEN; i++) begin
               base_in[63 - 8*i -: 8] = name_ff[i];
            end
            for (int i = 0; i < EXT_LEN; i++) begin
               ext_in[23 - 8*i -: 8] = name_ff[BASE_LEN + i];
            end
            base_lower_in = case_ff[0] && !case_ff[1];
            ext_lower_in  = case_ff[2] && !case_ff[3];
         end else begin
            base_in       = '0;
            ext_in        = '0;
            base_lower_in = 1'b0;
            ext_lower_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NAME_LEN; i++) begin
            name_ff[i] <= CH_SPACE;
         end
         position_ff  <= '0;
         phase_ff     <= PH_BASE;
         case_ff      <= '0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         name_ff      <= name_in;
         position_ff  <= position_in;
         phase_ff     <= phase_in;
         case_ff      <= case_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff       <= base_in;
      ext_ff        <= ext_in;
      base_lower_ff <= base_lower_in;
      ext_lower_ff  <= ext_lower_in;
      status_ff     <= status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_base_name  = base_ff;
   assign rsp_ext_name   = ext_ff;
   assign rsp_base_lower = base_lower_ff;
   assign rsp_ext_lower  = ext_lower_ff;
   assign rsp_status     = status_ff;

   a_base_pos: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BASE |-> position_ff < POS_BASE_END)
      else $error("base phase position out of range");

   a_after8_pos: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_AFTER8 |-> position_ff == POS_BASE_END)
      else $error("position not at extension start after eight base characters");

   a_nul_result: assert property (@(posedge clock) disable iff (reset)
      end_of_name |=> rsp_valid_ff && phase_ff == PH_BASE && position_ff == '0 && !bad_ff)
      else $error("end of name did not produce a result and clear state");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != ST_OK |-> base_ff == '0 && ext_ff == '0 &&
         !base_lower_ff && !ext_lower_ff)
      else $error("error result carries name data");

endmodule
